// File: hdl/bmp_to_panel_framebuffer_core_macros.svh
// assertion helpers shared by the checker
`ifndef BMP_TO_PANEL_FRAMEBUFFER_CORE_MACROS_SVH
`define BMP_TO_PANEL_FRAMEBUFFER_CORE_MACROS_SVH

// same-cycle implication
`define BMPFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpfb check failed");

// next-cycle implication
`define BMPFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpfb check failed");

`endif

// File: hdl/bmpfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmpfb_pkg;

    localparam int LEN_W     = 24;
    localparam int DIM_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int HDR_DEPTH = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH  = 2'd2;

    localparam logic OP_FILE_BYTE = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_SIGNATURE = 4'd2;
    localparam logic [3:0] ST_OFFSET    = 4'd3;
    localparam logic [3:0] ST_DIB       = 4'd4;
    localparam logic [3:0] ST_SIZE      = 4'd5;
    localparam logic [3:0] ST_BPP       = 4'd6;
    localparam logic [3:0] ST_HEIGHT    = 4'd7;
    localparam logic [3:0] ST_CAPACITY  = 4'd8;

    localparam logic [7:0]       SIG_B       = 8'h42;
    localparam logic [7:0]       SIG_M       = 8'h4D;
    localparam logic [LEN_W-1:0] HDR_MIN_LEN = 24'd14;
    localparam logic [LEN_W-1:0] DIB_LEN     = 24'd12;
    localparam logic [LEN_W-1:0] DECIDE_POS  = 24'd29;
    localparam logic [11:0]      ROW_SAT     = 12'd2048;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd400;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd300;

    typedef struct packed {
        logic clear_step;
        logic rd_issue;
        logic capture_read;
        logic take_byte;
        logic check;
        logic load_replay;
        logic feed_setup;
        logic feed_check;
        logic pair_read;
        logic pair_skip;
        logic pair_write;
        logic advance;
        logic capture_status;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic byte_ok;
        logic at_decide;
        logic at_last;
        logic feed_live;
        logic check_ok;
        logic replay_more;
        logic padded_zero;
        logic pair_go;
        logic pair_in_mem;
        logic pair_last;
        logic last_byte;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/bmpfb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpfb_ctrl
    import bmpfb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     opcode,
    output logic          in_ready,
    input  wire dp_stat_t st,
    output ctl_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_NEXT,
        S_FEED_SETUP,
        S_FEED_CHECK,
        S_FEED_PAIR,
        S_FEED_WRITE,
        S_ADVANCE,
        S_FINISH,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   replaying_reg, replaying_next;
    state_t after_feed;

    assign in_ready   = (state_reg == S_IDLE);
    assign after_feed = replaying_reg ? S_NEXT : S_FINISH;

    always_comb
    begin
        state_next     = state_reg;
        replaying_next = replaying_reg;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (st.clear_done)
                    state_next = S_NEXT;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_READ)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_READ;
                    end
                    else if (st.byte_ok)
                    begin
                        cmd.take_byte = 1'b1;
                        if (st.at_decide)
                            state_next = S_CHECK;
                        else if (st.feed_live)
                            state_next = S_FEED_SETUP;
                        else if (st.at_last)
                            state_next = S_FINISH;
                    end
                end
            end
            S_READ:
            begin
                cmd.capture_read = 1'b1;
                state_next       = S_EMIT;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.check_ok)
                begin
                    replaying_next = 1'b1;
                    state_next     = S_CLEAR;
                end
                else
                    state_next = S_FINISH;
            end
            S_NEXT:
            begin
                if (replaying_reg && st.replay_more)
                begin
                    cmd.load_replay = 1'b1;
                    state_next      = S_FEED_SETUP;
                end
                else
                begin
                    replaying_next = 1'b0;
                    state_next     = S_FINISH;
                end
            end
            S_FEED_SETUP:
            begin
                cmd.feed_setup = 1'b1;
                state_next     = S_FEED_CHECK;
            end
            S_FEED_CHECK:
            begin
                cmd.feed_check = 1'b1;
                state_next     = S_FEED_PAIR;
            end
            S_FEED_PAIR:
            begin
                priority if (st.padded_zero)
                    state_next = after_feed;
                else if (!st.pair_go)
                    state_next = S_ADVANCE;
                else if (st.pair_in_mem)
                begin
                    cmd.pair_read = 1'b1;
                    state_next    = S_FEED_WRITE;
                end
                else
                begin
                    cmd.pair_skip = 1'b1;
                    state_next    = st.pair_last ? S_ADVANCE : S_FEED_PAIR;
                end
            end
            S_FEED_WRITE:
            begin
                cmd.pair_write = 1'b1;
                state_next     = st.pair_last ? S_ADVANCE : S_FEED_PAIR;
            end
            S_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = after_feed;
            end
            S_FINISH:
            begin
                if (st.last_byte)
                begin
                    cmd.capture_status = 1'b1;
                    state_next         = S_EMIT;
                end
                else
                    state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!st.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            replaying_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            replaying_reg <= replaying_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/bmpfb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bmpfb_datapath
    import bmpfb_pkg::*;
#(
    parameter int FB_BYTES   = 16384,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data,
    input  wire logic [7:0]           file_byte,
    input  wire logic [13:0]          read_address,
    input  wire logic                 out_ready,
    input  wire ctl_cmd_t             cmd,
    output dp_stat_t                  st,
    output logic                      out_valid,
    output logic                      result_kind,
    output logic [3:0]                status,
    output logic [7:0]                read_data
);

    localparam int ADDR_W = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int IDX_W  = 21;
    localparam logic [IDX_W-1:0]  FB_C    = IDX_W'(FB_BYTES);
    localparam logic [ADDR_W-1:0] CLR_END = ADDR_W'(FB_BYTES - 1);
    localparam logic [12:0]       MAX_W_C = 13'(MAX_WIDTH);
    localparam logic [12:0]       MAX_H_C = 13'(MAX_HEIGHT);

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [LEN_W-1:0] len_reg;
    logic             restart;

    // file progress
    logic [LEN_W-1:0] pos_reg, off_reg, p_reg, replay_j_reg;
    logic             hv_reg, last_reg;
    logic [3:0]       pending_reg;
    logic [11:0]      row_reg;
    logic [7:0]       col_reg;
    logic [7:0]       hb_reg [HDR_DEPTH];
    logic [7:0]       hz [HDR_DEPTH];

    // pixel feed
    logic [7:0]       feed_byte_reg;
    logic [20:0]      prod_row_reg;
    logic [18:0]      prod_base_reg;
    logic             row_ok_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0]       pair_reg;

    // frame store
    logic [7:0]        mem [FB_BYTES];
    logic [7:0]        mem_rdata_reg;
    logic [ADDR_W-1:0] mem_addr, clr_idx_reg;
    logic [7:0]        mem_wdata;
    logic              mem_we;
    logic              addr_ok_reg;

    // results
    logic       res_kind_reg;
    logic [3:0] res_status_reg;
    logic [7:0] res_data_reg;
    logic       out_valid_reg;
    logic       out_kind_reg;
    logic [3:0] out_status_reg;
    logic [7:0] out_data_reg;

    logic [8:0]       row_bytes, padded, quad_rows;
    logic [9:0]       padded_sum;
    logic [LEN_W-1:0] len_m1;
    logic [31:0]      off32, w32, h32;
    logic [15:0]      bpp;
    logic [18:0]      fb_size;
    logic [3:0]       code;
    logic [10:0]      x_pos;
    logic [11:0]      x_odd;
    logic [7:0]       shifted_byte, mask_even, mask_odd;
    logic [8:0]       col_inc;
    logic [IDX_W-1:0] rd_ext;

    assign restart = cfg_write && (cfg_index == CFG_FILE_LENGTH);

    always_comb
    begin
        for (int j = 0; j < HDR_DEPTH; j++)
            hz[j] = (LEN_W'(j) < len_reg) ? hb_reg[j] : 8'h00;
    end

    assign off32   = {hz[13], hz[12], hz[11], hz[10]};
    assign w32     = {hz[21], hz[20], hz[19], hz[18]};
    assign h32     = {hz[25], hz[24], hz[23], hz[22]};
    assign bpp     = {hz[29], hz[28]};
    assign fb_size = width_reg[10:1] * height_reg[10:2];

    always_comb
    begin
        priority if (len_reg < HDR_MIN_LEN)
            code = ST_SHORT;
        else if (hz[0] != SIG_B || hz[1] != SIG_M)
            code = ST_SIGNATURE;
        else if (off32 >= {8'd0, len_reg} || off32 < {8'd0, HDR_MIN_LEN})
            code = ST_OFFSET;
        else if ({1'b0, off32} + {9'd0, DIB_LEN} > {9'd0, len_reg})
            code = ST_DIB;
        else if (w32 != {21'd0, width_reg} || h32 != {21'd0, height_reg})
            code = ST_SIZE;
        else if (bpp != 16'd1)
            code = ST_BPP;
        else if (height_reg == '0)
            code = ST_HEIGHT;
        else if ({2'b0, width_reg} > MAX_W_C || {2'b0, height_reg} > MAX_H_C)
            code = ST_CAPACITY;
        else if ({2'b0, fb_size} > FB_C)
            code = ST_CAPACITY;
        else
            code = ST_OK;
    end

    assign row_bytes  = 9'(({1'b0, width_reg} + 12'd7) >> 3);
    assign padded_sum = {1'b0, row_bytes} + 10'd3;
    assign padded     = {padded_sum[8:2], 2'b00};
    assign quad_rows  = height_reg[10:2];
    assign len_m1     = len_reg - 24'd1;

    assign x_pos        = {col_reg, 3'b000} + {8'd0, pair_reg, 1'b0};
    assign x_odd        = {1'b0, x_pos} + 12'd1;
    assign shifted_byte = feed_byte_reg << {pair_reg, 1'b0};
    assign mask_even    = 8'h80 >> {row_reg[1:0], 1'b0};
    assign mask_odd     = 8'h40 >> {row_reg[1:0], 1'b0};
    assign col_inc      = {1'b0, col_reg} + 9'd1;
    assign rd_ext       = {7'd0, read_address};

    always_comb
    begin
        st.clear_done  = (clr_idx_reg == CLR_END);
        st.byte_ok     = (pos_reg < len_reg);
        st.at_decide   = (len_m1 < DECIDE_POS) ? (pos_reg == len_m1)
                                               : (pos_reg == DECIDE_POS);
        st.at_last     = ({1'b0, pos_reg} + 25'd1) == {1'b0, len_reg};
        st.feed_live   = hv_reg && (pos_reg >= off_reg);
        st.check_ok    = (code == ST_OK);
        st.replay_more = (replay_j_reg <= p_reg);
        st.padded_zero = (padded == '0);
        st.pair_go     = row_ok_reg && (x_pos < width_reg);
        st.pair_in_mem = (idx_reg < FB_C);
        st.pair_last   = (pair_reg == 2'd3);
        st.last_byte   = last_reg;
        st.out_busy    = out_valid_reg && !out_ready;
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = 8'h00;
        mem_addr  = idx_reg[ADDR_W-1:0];
        if (cmd.clear_step)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_idx_reg;
        end
        else if (cmd.rd_issue)
            mem_addr = rd_ext[ADDR_W-1:0];
        else if (cmd.pair_read)
            mem_addr = idx_reg[ADDR_W-1:0];
        else if (cmd.pair_write)
        begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_reg
                      | (shifted_byte[7] ? mask_even : 8'h00)
                      | ((shifted_byte[6] && x_odd < {1'b0, width_reg}) ? mask_odd : 8'h00);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            len_reg       <= '0;
            pos_reg       <= '0;
            off_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            hv_reg        <= 1'b0;
            pending_reg   <= ST_OK;
            last_reg      <= 1'b0;
            replay_j_reg  <= '0;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_PANEL_WIDTH)
                width_reg <= cfg_data[DIM_W-1:0];
            if (cfg_write && cfg_index == CFG_PANEL_HEIGHT)
                height_reg <= cfg_data[DIM_W-1:0];
            if (restart)
            begin
                len_reg     <= cfg_data;
                pos_reg     <= '0;
                off_reg     <= '0;
                row_reg     <= '0;
                col_reg     <= '0;
                hv_reg      <= 1'b0;
                pending_reg <= ST_OK;
                last_reg    <= 1'b0;
            end
            if (cmd.clear_step)
                clr_idx_reg <= st.clear_done ? '0 : clr_idx_reg + 1'b1;
            if (cmd.take_byte)
            begin
                pos_reg  <= pos_reg + 24'd1;
                last_reg <= st.at_last;
            end
            if (cmd.check)
            begin
                pending_reg <= code;
                if (code == ST_OK)
                begin
                    hv_reg       <= 1'b1;
                    off_reg      <= off32[LEN_W-1:0];
                    replay_j_reg <= off32[LEN_W-1:0];
                    row_reg      <= '0;
                    col_reg      <= '0;
                end
            end
            if (cmd.load_replay)
                replay_j_reg <= replay_j_reg + 24'd1;
            if (cmd.advance)
            begin
                if (col_inc >= padded)
                begin
                    col_reg <= '0;
                    if (row_reg != ROW_SAT)
                        row_reg <= row_reg + 12'd1;
                end
                else
                    col_reg <= col_inc[7:0];
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            p_reg         <= pos_reg;
            feed_byte_reg <= file_byte;
            if (pos_reg[LEN_W-1:5] == '0)
                hb_reg[pos_reg[4:0]] <= file_byte;
        end
        if (cmd.load_replay)
            feed_byte_reg <= hb_reg[replay_j_reg[4:0]];
        if (cmd.rd_issue)
            addr_ok_reg <= (rd_ext < FB_C);
        if (cmd.feed_setup)
        begin
            prod_row_reg  <= (row_reg + 12'd1) * padded;
            prod_base_reg <= {col_reg, 2'b00} * quad_rows;
        end
        if (cmd.feed_check)
        begin
            row_ok_reg <= ({1'b0, row_reg} < {2'b0, height_reg})
                       && ({1'b0, col_reg} < row_bytes)
                       && ({1'b0, off_reg} + {4'd0, prod_row_reg} <= {1'b0, len_reg});
            idx_reg    <= {2'b0, prod_base_reg} + {11'd0, row_reg[11:2]};
            pair_reg   <= '0;
        end
        if (cmd.pair_skip || cmd.pair_write)
        begin
            pair_reg <= pair_reg + 2'd1;
            idx_reg  <= idx_reg + {12'd0, quad_rows};
        end
        if (cmd.capture_read)
        begin
            res_kind_reg   <= KIND_READ;
            res_status_reg <= ST_OK;
            res_data_reg   <= addr_ok_reg ? mem_rdata_reg : 8'h00;
        end
        if (cmd.capture_status)
        begin
            res_kind_reg   <= KIND_STATUS;
            res_status_reg <= pending_reg;
            res_data_reg   <= 8'h00;
        end
        if (cmd.load_out)
        begin
            out_kind_reg   <= res_kind_reg;
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign status      = out_status_reg;
    assign read_data   = out_data_reg;

endmodule

`default_nettype wire

// File: hdl/bmp_to_panel_framebuffer_core.sv
// 1-bpp bottom-up bmp to panel framebuffer converter
// input channel (in_valid/in_ready): opcode 0 streams the next file byte,
// opcode 1 requests the framebuffer byte at read_address
// output channel (out_valid/out_ready): one status request after the final
// file byte, one read-data request for each read
// config port: cfg_write with cfg_index 0 width, 1 height, 2 file length;
// writing the file length starts a new file, the frame store is kept
// a read passes the store's read register and the result register on to the output
// register; a pixel byte is set up and checked, then each framebuffer byte it touches
// takes a read-modify-write on the single-port frame store;
// the byte that completes a passing header check clears the whole frame store,
// then replays any pixel bytes already received from the header
// after reset the frame store is cleared, with in_ready low until it is done
// a stalled receiver holds the result in the output register; the block
// keeps taking requests until it has another result to hand over
`timescale 1ns / 1ps
`default_nettype none

module bmp_to_panel_framebuffer_core
    import bmpfb_pkg::*;
#(
    parameter int FB_BYTES   = 16384,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [7:0]           file_byte,
    input  wire logic [13:0]          read_address,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      result_kind,
    output logic [3:0]                status,
    output logic [7:0]                read_data
);

    ctl_cmd_t cmd;
    dp_stat_t st;

    bmpfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bmpfb_datapath #(
        .FB_BYTES   (FB_BYTES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .file_byte    (file_byte),
        .read_address (read_address),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .status       (status),
        .read_data    (read_data)
    );

endmodule

`default_nettype wire

// File: hdl/bmpfb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bmp_to_panel_framebuffer_core_macros.svh"

module bmpfb_checker
    import bmpfb_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cfg_write,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [LEN_W-1:0]     cfg_data,
    input wire logic                 in_valid,
    input wire logic                 in_ready,
    input wire logic                 opcode,
    input wire logic [7:0]           file_byte,
    input wire logic [13:0]          read_address,
    input wire logic                 out_valid,
    input wire logic                 out_ready,
    input wire logic                 result_kind,
    input wire logic [3:0]           status,
    input wire logic [7:0]           read_data
);

    // stalled result holds
    `BMPFB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(status) && $stable(read_data))

    // a read request keeps the block busy for the next cycle
    `BMPFB_ASSERT_NEXT(a_read_busy, in_valid && in_ready && opcode == OP_READ, !in_ready)

    // no result appears the cycle straight after a request is taken
    `BMPFB_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

    // read data carries a zero status
    `BMPFB_ASSERT_SAME(a_read_status_zero, out_valid && result_kind == KIND_READ, status == ST_OK)

endmodule

bind bmp_to_panel_framebuffer_core bmpfb_checker u_bmpfb_checker (.*);

`default_nettype wire
